// ===== hdl/mpl_pkg.sv =====
package mpl_pkg;

    // Width of every length field on the input side and of the count field
    localparam int LEN_W       = 13;
    localparam int NUM_PIECES  = 3;

    // Recent results kept in the cell row; longer pieces are served by the tables
    localparam int HIST_DEPTH  = 4;

    // Beat layouts
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;

    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

endpackage

// ===== hdl/mpl_ram.sv =====
module mpl_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4097
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mpl_cell.sv =====
module mpl_cell #(
    parameter int CNT_W = 13,
    parameter int SLOT  = 1
) (
    input  logic                                             i_clk,
    input  logic                                             i_shift,
    input  logic [CNT_W-1:0]                                 i_val,
    input  mpl_pkg::t_len [mpl_pkg::NUM_PIECES-1:0]          i_piece,
    input  logic [mpl_pkg::NUM_PIECES-1:0][CNT_W-1:0]        i_tap,
    output logic [CNT_W-1:0]                                 o_val,
    output logic [mpl_pkg::NUM_PIECES-1:0][CNT_W-1:0]        o_tap
);

    // Holds the entry SLOT positions above the one being solved
    logic [CNT_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_val;
        end
    end

    assign o_val = r_val;

    // Drive the tap bus of every piece whose length lands on this slot
    always_comb begin
        for (int j = 0; j < mpl_pkg::NUM_PIECES; j++) begin
            o_tap[j] = i_tap[j]
                     | ((i_piece[j] == mpl_pkg::LEN_W'(SLOT)) ? r_val : '0);
        end
    end

endmodule

// ===== hdl/max_pieces_three_lengths_top.sv =====
// Cut-ribbon solver: greatest number of pieces of three allowed lengths that
// add up exactly to a total length.
//
// Slave channel: one beat per request. i_s_tdata = total_length, piece_a,
// piece_b, piece_c (13 bits each, lowest first). Master channel: one beat
// per request, o_m_tdata = max_pieces, o_m_tuser = reachable.
//
// The solver walks the position from total_length down to zero, one table
// entry per cycle. A request is taken only while the solver is idle. The
// walk cannot go faster, as each entry needs the one just before it. A
// total above MAX_LEN is answered as not reachable without a walk, through
// the FINISH state.
//
// Recent entries live in a row of four cells that shift while the solver
// runs; older entries come from three identical tables (one read port each).
// Reset idles the solver and drops a pending result; the tables are not
// cleared, as each request writes every entry it reads. When the receiver
// stalls, the result waits in the output register and the next request is
// still taken and solved; only its result then waits for the register.
module max_pieces_three_lengths_top #(
    parameter int MAX_LEN = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // total_length[12:0], piece_a[25:13], piece_b[38:26], piece_c[51:39]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mpl_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // max_pieces[12:0]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mpl_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // reachable[0]
    output logic [mpl_pkg::OUT_TUSER_W-1:0]    o_m_tuser
);

    localparam int CNT_W = $clog2(MAX_LEN + 2);   // entry = count + 1, 0 = unreachable
    localparam int DEPTH = MAX_LEN + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = mpl_pkg::LEN_W;
    localparam int NP    = mpl_pkg::NUM_PIECES;
    localparam int HD    = mpl_pkg::HIST_DEPTH;

    // ---------------------------------------------------------------
    // Input fields
    // ---------------------------------------------------------------
    mpl_pkg::t_len                  w_in_total;
    mpl_pkg::t_len [NP-1:0]         w_in_piece;

    assign w_in_total    = i_s_tdata[LW-1:0];
    assign w_in_piece[0] = i_s_tdata[2*LW-1:LW];
    assign w_in_piece[1] = i_s_tdata[3*LW-1:2*LW];
    assign w_in_piece[2] = i_s_tdata[4*LW-1:3*LW];

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    mpl_pkg::t_state                r_state, n_state;
    mpl_pkg::t_len                  r_total;
    mpl_pkg::t_len [NP-1:0]         r_piece;
    mpl_pkg::t_len                  r_pos;          // entry solved this cycle
    logic                           r_first;        // solving the top entry
    logic                           r_wr_en;
    logic [AW-1:0]                  r_wr_addr;
    logic [CNT_W-1:0]               r_wr_data;
    mpl_pkg::t_len                  r_res_cnt;
    logic                           r_res_ok;
    logic                           r_m_valid;
    mpl_pkg::t_len                  r_m_cnt;
    logic                           r_m_ok;

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    logic w_accept;
    logic w_too_long;
    logic w_run;
    logic w_out_free;
    logic w_out_load;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_too_long = 32'(w_in_total) > 32'(MAX_LEN);
    assign w_out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpl_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = w_too_long ? mpl_pkg::ST_FINISH : mpl_pkg::ST_RUN;
                end
            end
            mpl_pkg::ST_RUN: begin
                if (r_pos == '0) begin
                    n_state = mpl_pkg::ST_FINISH;
                end
            end
            mpl_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = mpl_pkg::ST_IDLE;
                end
            end
            default: n_state = mpl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_run      = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            mpl_pkg::ST_IDLE:   o_s_tready = 1'b1;
            mpl_pkg::ST_RUN:    w_run      = 1'b1;
            mpl_pkg::ST_FINISH: w_out_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mpl_pkg::ST_IDLE;
            r_wr_en   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr_en <= w_run;
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tables: read the entry one piece above the next position, so the
    // data is there when that position is solved. Writes are registered first.
    // ---------------------------------------------------------------
    logic [NP-1:0][CNT_W-1:0] w_ram_q;
    logic [AW-1:0]            w_rd_addr [NP];

    for (genvar j = 0; j < NP; j++) begin : g_tbl
        assign w_rd_addr[j] = AW'({1'b0, r_pos} + {1'b0, r_piece[j]} - (LW+1)'(1));

        mpl_ram #(
            .WIDTH (CNT_W),
            .DEPTH (DEPTH)
        ) u_tbl (
            .i_clk   (i_clk),
            .i_we    (r_wr_en),
            .i_waddr (r_wr_addr),
            .i_wdata (r_wr_data),
            .i_raddr (w_rd_addr[j]),
            .o_rdata (w_ram_q[j])
        );
    end

    // ---------------------------------------------------------------
    // Cell row: cell k holds the entry k positions above r_pos
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]         w_new;
    logic [CNT_W-1:0]         w_hist [HD];
    logic [NP-1:0][CNT_W-1:0] w_tap  [HD+1];

    assign w_hist[0] = w_new;
    assign w_tap[0]  = '0;

    for (genvar k = 1; k <= HD; k++) begin : g_cell
        if (k < HD) begin : g_mid
            mpl_cell #(
                .CNT_W (CNT_W),
                .SLOT  (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_run),
                .i_val   (w_hist[k-1]),
                .i_piece (r_piece),
                .i_tap   (w_tap[k-1]),
                .o_val   (w_hist[k]),
                .o_tap   (w_tap[k])
            );
        end else begin : g_end
            mpl_cell #(
                .CNT_W (CNT_W),
                .SLOT  (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_run),
                .i_val   (w_hist[k-1]),
                .i_piece (r_piece),
                .i_tap   (w_tap[k-1]),
                .o_val   (),
                .o_tap   (w_tap[k])
            );
        end
    end

    // ---------------------------------------------------------------
    // Entry for r_pos: 1 at the top entry, else best of the three pieces,
    // each nonzero, one past a reachable entry and not overshooting the total
    // ---------------------------------------------------------------
    mpl_pkg::t_len            w_rem;
    logic [NP-1:0][CNT_W-1:0] w_cand;
    logic [CNT_W-1:0]         w_best;

    assign w_rem = r_total - r_pos;

    always_comb begin
        logic [CNT_W-1:0] v;
        logic             fits;
        for (int j = 0; j < NP; j++) begin
            fits = (r_piece[j] != '0) && (r_piece[j] <= w_rem);
            v    = (r_piece[j] <= LW'(HD)) ? w_tap[HD][j] : w_ram_q[j];
            w_cand[j] = (fits && (v != '0)) ? v + CNT_W'(1) : '0;
        end
    end

    always_comb begin
        w_best = w_cand[0];
        for (int j = 1; j < NP; j++) begin
            if (w_cand[j] > w_best) begin
                w_best = w_cand[j];
            end
        end
    end

    assign w_new = r_first ? CNT_W'(1) : w_best;

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_total   <= w_in_total;
            r_piece   <= w_in_piece;
            r_pos     <= w_in_total;
            r_first   <= 1'b1;
            r_res_cnt <= '0;
            r_res_ok  <= 1'b0;
        end
        if (w_run) begin
            r_pos     <= r_pos - LW'(1);
            r_first   <= 1'b0;
            r_wr_addr <= AW'(r_pos);
            r_wr_data <= w_new;
            if (r_pos == '0) begin
                r_res_ok  <= (w_new != '0);
                r_res_cnt <= (w_new != '0) ? LW'(w_new - CNT_W'(1)) : '0;
            end
        end
        if (w_out_load) begin
            r_m_cnt <= r_res_cnt;
            r_m_ok  <= r_res_ok;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = mpl_pkg::OUT_TDATA_W'(r_m_cnt);
    assign o_m_tuser  = r_m_ok;

endmodule

// ===== hdl/mpl_chk.sv =====
module mpl_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [mpl_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input logic [mpl_pkg::OUT_TUSER_W-1:0]    o_m_tuser
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // Unreachable total carries a zero count
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[mpl_pkg::LEN_W-1:0] == '0))
        else $error("unreachable result with nonzero count");

    // Solver is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while solving");

    // A new result only comes out of a busy solver
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result without a request in work");

    // Padding of the result beat stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[mpl_pkg::OUT_TDATA_W-1:mpl_pkg::LEN_W] == '0))
        else $error("result padding not zero");

endmodule

bind max_pieces_three_lengths_top mpl_chk u_chk (.*);
